[design/wsoma_pkg.sv]
// ============================================================================
// wsoma_pkg
// Shared types and constants for the wheel speed moving average block.
// ============================================================================
package wsoma_pkg;

	// Window length in samples
	localparam int WINDOW  = 10;
	localparam int NUM_CH  = 4;
	localparam int WORD_W  = 16;
	localparam int LIMIT_W = 15;

	// Slot index and running sum widths
	localparam int SLOT_W  = $clog2(WINDOW);
	localparam int CLOG_W  = $clog2(WINDOW);
	localparam int SUM_W   = WORD_W + CLOG_W;

	// Rounded divide by WINDOW: q = ((|sum| + WINDOW/2) * RECIP) >> SHIFT
	localparam int SHIFT   = SUM_W + CLOG_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	localparam logic [SUM_W-1:0] HALF = SUM_W'(WINDOW / 2);

	// Channels whose average leaves the block negated (rear right, front right)
	localparam logic [NUM_CH-1:0] NEG_MASK = 4'b1100;

	// Queue geometry
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef logic signed [WORD_W-1:0] word_t;

	// Speeds in ring order: front left, rear left, rear right, front right
	typedef struct packed {
		word_t [NUM_CH-1:0] speed;
		word_t              steer;
	} sample_t;

	typedef struct packed {
		word_t [NUM_CH-1:0] avg;
		word_t              steer;
	} result_t;

	localparam int ITEM_W = $bits(sample_t);

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

[design/wsoma_fifo.sv]
// ============================================================================
// wsoma_fifo
// Small register FIFO used between the front and back ends and on the output.
// ============================================================================
module wsoma_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [wsoma_pkg::ITEM_W-1:0]  wr_data,
	input  logic                          rd_en,
	output logic [wsoma_pkg::ITEM_W-1:0]  rd_data,
	output wsoma_pkg::fifo_status_t       status
);

	logic [wsoma_pkg::ITEM_W-1:0] mem_q [wsoma_pkg::FIFO_DEPTH];
	logic [wsoma_pkg::PTR_W-1:0]  wr_ptr_q;
	logic [wsoma_pkg::PTR_W-1:0]  rd_ptr_q;
	logic [wsoma_pkg::CNT_W-1:0]  count_q;
	logic                         do_wr;
	logic                         do_rd;

	assign status.full  = (count_q == wsoma_pkg::CNT_W'(wsoma_pkg::FIFO_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_wr        = wr_en && !status.full;
	assign do_rd        = rd_en && !status.empty;
	assign rd_data      = mem_q[rd_ptr_q];

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + wsoma_pkg::CNT_W'(do_wr) - wsoma_pkg::CNT_W'(do_rd);
		end
	end

	// Storage, no reset
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Upstream must never write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !status.full)
		else $error("write into full queue");

endmodule

[design/wsoma_front.sv]
// ============================================================================
// wsoma_front
// Takes samples, holds the reject limit and drops samples with outlier speeds.
// ============================================================================
module wsoma_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wsoma_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic                          push,
	input  wsoma_pkg::sample_t            sample,
	input  wsoma_pkg::fifo_status_t       mid_status,
	output logic                          full,
	output logic                          mid_wr,
	output logic [wsoma_pkg::ITEM_W-1:0]  mid_data
);

	logic [wsoma_pkg::LIMIT_W-1:0]  reject_limit_q;
	logic [wsoma_pkg::NUM_CH-1:0]   outlier;
	logic [wsoma_pkg::WORD_W-1:0]   mag [wsoma_pkg::NUM_CH];

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_limit_q <= wsoma_pkg::LIMIT_W'(19200);
		end else if (cfg_we) begin
			reject_limit_q <= cfg_wdata;
		end
	end

	// Magnitude check; -32768 has magnitude 32768 and always rejects
	always_comb begin
		for (int c = 0; c < wsoma_pkg::NUM_CH; c++) begin
			mag[c] = sample.speed[c][wsoma_pkg::WORD_W-1] ?
				wsoma_pkg::WORD_W'(-sample.speed[c]) : wsoma_pkg::WORD_W'(sample.speed[c]);
			outlier[c] = (mag[c] > {1'b0, reject_limit_q});
		end
	end

	assign full     = mid_status.full;
	assign mid_wr   = push && !mid_status.full && (outlier == '0);
	assign mid_data = sample;

	// Limit tracks the last configuration write
	a_limit_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> reject_limit_q == $past(cfg_wdata))
		else $error("reject limit not updated");

endmodule

[design/wsoma_back.sv]
// ============================================================================
// wsoma_back
// Ring update, running sums and rounded averaging pipeline with output credits.
// ============================================================================
module wsoma_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wsoma_pkg::fifo_status_t       mid_status,
	input  logic [wsoma_pkg::ITEM_W-1:0]  mid_data,
	output logic                          mid_rd,
	input  logic                          out_xfer,
	output logic                          out_wr,
	output logic [wsoma_pkg::ITEM_W-1:0]  out_data
);

	localparam int QW = wsoma_pkg::WORD_W;
	localparam int SW = wsoma_pkg::SUM_W;

	wsoma_pkg::sample_t            item;
	wsoma_pkg::result_t            res;
	logic                          issue;

	// Ring state
	wsoma_pkg::word_t [wsoma_pkg::NUM_CH-1:0] ring_q [wsoma_pkg::WINDOW];
	logic [wsoma_pkg::WINDOW-1:0]  valid_q;
	logic [wsoma_pkg::SLOT_W-1:0]  slot_q;
	logic signed [SW-1:0]          sums_q  [wsoma_pkg::NUM_CH];
	logic signed [SW-1:0]          sum_nxt [wsoma_pkg::NUM_CH];
	logic [wsoma_pkg::CNT_W-1:0]   credit_q;

	// Pipeline stages
	logic                          vld_s1, vld_s2, vld_s3;
	logic signed [SW-1:0]          sum_s1  [wsoma_pkg::NUM_CH];
	logic [SW-1:0]                 mag_s2  [wsoma_pkg::NUM_CH];
	logic [wsoma_pkg::NUM_CH-1:0]  neg_s2, neg_s3;
	logic [wsoma_pkg::PROD_W-1:0]  prod_s3 [wsoma_pkg::NUM_CH];
	wsoma_pkg::word_t              steer_s1, steer_s2, steer_s3;
	logic [QW-1:0]                 quo     [wsoma_pkg::NUM_CH];

	assign item   = wsoma_pkg::sample_t'(mid_data);
	// Issue only while the output queue has room for everything in flight
	assign issue  = !mid_status.empty &&
		(credit_q < wsoma_pkg::CNT_W'(wsoma_pkg::FIFO_DEPTH));
	assign mid_rd = issue;

	// New running sums: add incoming speed, drop the one it overwrites
	always_comb begin
		for (int c = 0; c < wsoma_pkg::NUM_CH; c++) begin
			sum_nxt[c] = sums_q[c]
				+ {{(SW-QW){item.speed[c][QW-1]}}, item.speed[c]}
				- (valid_q[slot_q] ?
					{{(SW-QW){ring_q[slot_q][c][QW-1]}}, ring_q[slot_q][c]} : SW'(0));
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			valid_q  <= '0;
			credit_q <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			for (int c = 0; c < wsoma_pkg::NUM_CH; c++) begin
				sums_q[c] <= '0;
			end
		end else begin
			vld_s1   <= issue;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			credit_q <= credit_q + wsoma_pkg::CNT_W'(issue) - wsoma_pkg::CNT_W'(out_xfer);
			if (issue) begin
				valid_q[slot_q] <= 1'b1;
				slot_q <= (slot_q == wsoma_pkg::SLOT_W'(wsoma_pkg::WINDOW - 1)) ?
					'0 : slot_q + 1'b1;
				for (int c = 0; c < wsoma_pkg::NUM_CH; c++) begin
					sums_q[c] <= sum_nxt[c];
				end
			end
		end
	end

	// Ring rows and pipeline payload, no reset
	always_ff @(posedge clk) begin
		if (issue) begin
			ring_q[slot_q] <= item.speed;
		end
		steer_s1 <= item.steer;
		steer_s2 <= steer_s1;
		steer_s3 <= steer_s2;
		neg_s3   <= neg_s2;
		for (int c = 0; c < wsoma_pkg::NUM_CH; c++) begin
			sum_s1[c]  <= sum_nxt[c];
			// Stage 2: magnitude plus half window for round to nearest
			neg_s2[c]  <= sum_s1[c][SW-1];
			mag_s2[c]  <= (sum_s1[c][SW-1] ? SW'(-sum_s1[c]) : SW'(sum_s1[c]))
				+ wsoma_pkg::HALF;
			// Stage 3: divide by reciprocal multiply
			prod_s3[c] <= wsoma_pkg::PROD_W'(mag_s2[c]) *
				wsoma_pkg::PROD_W'(wsoma_pkg::RECIP);
		end
	end

	// Restore sign, negate channels c and d
	always_comb begin
		for (int c = 0; c < wsoma_pkg::NUM_CH; c++) begin
			quo[c]     = prod_s3[c][wsoma_pkg::SHIFT +: QW];
			res.avg[c] = (neg_s3[c] ^ wsoma_pkg::NEG_MASK[c]) ? QW'(-quo[c]) : quo[c];
		end
		res.steer = steer_s3;
	end

	assign out_wr   = vld_s3;
	assign out_data = res;

	// Credits cover every item in flight
	a_credit_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 || vld_s2 || vld_s3) |-> credit_q != '0)
		else $error("item in flight without credit");

	a_credit_range: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= wsoma_pkg::CNT_W'(wsoma_pkg::FIFO_DEPTH))
		else $error("credit count overflow");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> slot_q <= wsoma_pkg::SLOT_W'(wsoma_pkg::WINDOW - 1))
		else $error("write slot out of range");

endmodule

[design/wheel_speed_outlier_moving_average_top.sv]
// ============================================================================
// wheel_speed_outlier_moving_average_top
// Moving average of four wheel speeds over a ten sample ring, with outliers
// dropped and the steering angle passed along.
// ============================================================================
//
//  channel   handshake            payload
//  -------   ------------------   --------------------------------------------
//  input     push / full          speed_front_left .. speed_rear_right, steer_in
//  result    empty / pop          avg_channel_a .. avg_channel_d, steer_out
//  config    cfg_we               cfg_wdata (reject limit, Q9.6)
//
//  One sample per cycle sustained while results are popped. A sample passes
//  the front check and middle queue write, then the ring and sum update,
//  rounding and reciprocal multiply stages in the back end, then the result
//  queue write, after which it can be popped.
//  Reset clears the ring valid bits and sums at once; there is no clearing pass.
//  full rises when the eight entry middle queue fills, which happens only
//  while the result queue is held by a stalled pop and its credits are used up.
//  Rejected samples leave no result.
//
module wheel_speed_outlier_moving_average_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wsoma_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic                          push,
	output logic                          full,
	input  logic signed [15:0]            speed_front_left,
	input  logic signed [15:0]            speed_front_right,
	input  logic signed [15:0]            speed_rear_left,
	input  logic signed [15:0]            speed_rear_right,
	input  logic signed [15:0]            steer_in,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [15:0]            avg_channel_a,
	output logic signed [15:0]            avg_channel_b,
	output logic signed [15:0]            avg_channel_c,
	output logic signed [15:0]            avg_channel_d,
	output logic signed [15:0]            steer_out
);

	wsoma_pkg::sample_t            sample;
	wsoma_pkg::result_t            res;
	wsoma_pkg::fifo_status_t       mid_status;
	wsoma_pkg::fifo_status_t       out_status;
	logic                          mid_wr, mid_rd, out_wr, out_xfer;
	logic [wsoma_pkg::ITEM_W-1:0]  mid_wdata, mid_rdata, out_wdata, out_rdata;

	// Ring channel order
	assign sample.speed[0] = speed_front_left;
	assign sample.speed[1] = speed_rear_left;
	assign sample.speed[2] = speed_rear_right;
	assign sample.speed[3] = speed_front_right;
	assign sample.steer    = steer_in;

	wsoma_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.push       (push),
		.sample     (sample),
		.mid_status (mid_status),
		.full       (full),
		.mid_wr     (mid_wr),
		.mid_data   (mid_wdata)
	);

	wsoma_fifo u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (mid_wdata),
		.rd_en   (mid_rd),
		.rd_data (mid_rdata),
		.status  (mid_status)
	);

	wsoma_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mid_status (mid_status),
		.mid_data   (mid_rdata),
		.mid_rd     (mid_rd),
		.out_xfer   (out_xfer),
		.out_wr     (out_wr),
		.out_data   (out_wdata)
	);

	wsoma_fifo u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (out_wdata),
		.rd_en   (pop),
		.rd_data (out_rdata),
		.status  (out_status)
	);

	// Result side
	assign out_xfer      = pop && !out_status.empty;
	assign empty         = out_status.empty;
	assign res           = wsoma_pkg::result_t'(out_rdata);
	assign avg_channel_a = res.avg[0];
	assign avg_channel_b = res.avg[1];
	assign avg_channel_c = res.avg[2];
	assign avg_channel_d = res.avg[3];
	assign steer_out     = res.steer;

endmodule
